// ----- src/utb_pkg.sv -----
// Package for the UUID text parser: field codes, string layout constants and decode helpers.
package utb_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned NIB_W = 4;
  localparam int unsigned NUM_BYTES = 16;
  localparam int unsigned HALF_W = 64;

  localparam logic [POS_W-1:0] UUID_TEXT_LEN = POS_W'(36);
  localparam logic [POS_W-1:0] POS_SATURATE = POS_W'(37);
  localparam logic [UNIT_W-1:0] DASH_UNIT = 16'h002D;
  localparam logic [UNIT_W-1:0] END_UNIT = 16'h0000;

  // input action codes
  localparam logic ACT_UNIT = 1'b0;
  localparam logic ACT_NIL = 1'b1;

  // result status codes
  localparam logic ST_OK = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  typedef struct packed {
    logic       dash;     // position must hold '-'
    logic [3:0] byte_idx; // target byte in the binary layout
    logic       low_nib;  // digit goes to the low nibble
  } slot_t;

  typedef struct packed {
    logic             hex;
    logic [NIB_W-1:0] value;
  } digit_t;

  // Text position to binary slot; the first three groups are byte-reversed.
  function automatic slot_t slot_of_pos(input logic [POS_W-1:0] pos);
    logic [4:0] slot;
    slot_t      s;
    s = '0;
    slot = '0;
    unique case (pos)
      6'd0:  slot = 5'd6;
      6'd1:  slot = 5'd7;
      6'd2:  slot = 5'd4;
      6'd3:  slot = 5'd5;
      6'd4:  slot = 5'd2;
      6'd5:  slot = 5'd3;
      6'd6:  slot = 5'd0;
      6'd7:  slot = 5'd1;
      6'd9:  slot = 5'd10;
      6'd10: slot = 5'd11;
      6'd11: slot = 5'd8;
      6'd12: slot = 5'd9;
      6'd14: slot = 5'd14;
      6'd15: slot = 5'd15;
      6'd16: slot = 5'd12;
      6'd17: slot = 5'd13;
      6'd19: slot = 5'd16;
      6'd20: slot = 5'd17;
      6'd21: slot = 5'd18;
      6'd22: slot = 5'd19;
      6'd24: slot = 5'd20;
      6'd25: slot = 5'd21;
      6'd26: slot = 5'd22;
      6'd27: slot = 5'd23;
      6'd28: slot = 5'd24;
      6'd29: slot = 5'd25;
      6'd30: slot = 5'd26;
      6'd31: slot = 5'd27;
      6'd32: slot = 5'd28;
      6'd33: slot = 5'd29;
      6'd34: slot = 5'd30;
      6'd35: slot = 5'd31;
      default: s.dash = 1'b1; // dash positions; past the end the result is unused
    endcase
    s.byte_idx = slot[4:1];
    s.low_nib = slot[0];
    return s;
  endfunction

  // Case-insensitive hex digit, full 16-bit compare.
  function automatic digit_t hex_digit(input logic [UNIT_W-1:0] u);
    digit_t d;
    d = '0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      d.hex = 1'b1;
      d.value = NIB_W'(u - 16'h0030);
    end else if (u >= 16'h0061 && u <= 16'h0066) begin
      d.hex = 1'b1;
      d.value = NIB_W'(u - 16'h0057);
    end else if (u >= 16'h0041 && u <= 16'h0046) begin
      d.hex = 1'b1;
      d.value = NIB_W'(u - 16'h0037);
    end
    return d;
  endfunction

endpackage

// ----- src/utb_if.sv -----
// Channel interfaces: code unit words in, parsed UUID words out.
interface utb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [utb_pkg::UNIT_W-1:0]   code_unit;
  modport source(output valid, action, code_unit, input ready);
  modport sink(input valid, action, code_unit, output ready);
endinterface

interface utb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [utb_pkg::HALF_W-1:0]   bytes_low;
  logic [utb_pkg::HALF_W-1:0]   bytes_high;
  modport source(output valid, status, bytes_low, bytes_high, input ready);
  modport sink(input valid, status, bytes_low, bytes_high, output ready);
endinterface

// ----- src/uuid_text_to_bytes.sv -----
// Top level: unbraced UUID text parser, one UTF-16 code unit per word.
//
//  channel   dir  payload                          word
//  in_word   in   action, code_unit[15:0]          one code unit, or a nil request
//  out_word  out  status, bytes_low, bytes_high    one result per terminator or nil
//
// One word per cycle while in_word.ready is high; a word is checked and stored
// in the cycle it is taken. A result sits in the output register from the cycle
// after its terminator or nil word is taken and stays there until taken.
// in_word.ready is low only while a result waits and out_word.ready is low.
// rst_n (synchronous) clears the position count, the error flag and the
// output valid; the assembled bytes are not reset.
module uuid_text_to_bytes (
  input  logic        clk,
  input  logic        rst_n,
  utb_in_if.sink      in_word,
  utb_out_if.source   out_word
);

  // string state
  logic [utb_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      bad_r, bad_nxt;
  logic [7:0]                bytes_r [utb_pkg::NUM_BYTES];

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic                       status_r;
  logic [utb_pkg::HALF_W-1:0] bytes_low_r, bytes_high_r;

  logic                       accept;
  logic                       is_nil, is_end, is_char, in_text, ok;
  utb_pkg::slot_t             slot;
  utb_pkg::digit_t            digit;
  logic                       nib_we;
  logic [utb_pkg::HALF_W-1:0] asm_low, asm_high;

  // output register frees up whenever its word is taken
  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept = in_word.valid && in_word.ready;

  assign is_nil = (in_word.action == utb_pkg::ACT_NIL);
  assign is_end = !is_nil && (in_word.code_unit == utb_pkg::END_UNIT);
  assign is_char = !is_nil && !is_end;
  assign in_text = (pos_r < utb_pkg::UUID_TEXT_LEN);

  assign slot = utb_pkg::slot_of_pos(pos_r);
  assign digit = utb_pkg::hex_digit(in_word.code_unit);
  assign nib_we = accept && is_char && in_text && !slot.dash && digit.hex;

  assign ok = (pos_r == utb_pkg::UUID_TEXT_LEN) && !bad_r;

  // bytes 0..7 and 8..15, little end first
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      asm_low[8*i +: 8] = bytes_r[i];
      asm_high[8*i +: 8] = bytes_r[8+i];
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    bad_nxt = bad_r;
    if (accept) begin
      if (is_char) begin
        if (in_text) begin
          if (slot.dash) begin
            if (in_word.code_unit != utb_pkg::DASH_UNIT) begin
              bad_nxt = 1'b1;
            end
          end else if (!digit.hex) begin
            bad_nxt = 1'b1;
          end
        end
        // count stops one past full length; too long still fails
        if (pos_r < utb_pkg::POS_SATURATE) begin
          pos_nxt = pos_r + 1'b1;
        end
      end else begin
        pos_nxt = '0;
        bad_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && !is_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bad_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      bad_r <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // nibble write into the assembly buffer
  always_ff @(posedge clk) begin
    if (nib_we) begin
      if (slot.low_nib) begin
        bytes_r[slot.byte_idx][3:0] <= digit.value;
      end else begin
        bytes_r[slot.byte_idx][7:4] <= digit.value;
      end
    end
  end

  // result payload: bytes only on a good string, zero for nil or failure
  always_ff @(posedge clk) begin
    if (accept && !is_char) begin
      if (is_nil) begin
        status_r <= utb_pkg::ST_OK;
        bytes_low_r <= '0;
        bytes_high_r <= '0;
      end else if (ok) begin
        status_r <= utb_pkg::ST_OK;
        bytes_low_r <= asm_low;
        bytes_high_r <= asm_high;
      end else begin
        status_r <= utb_pkg::ST_INVALID;
        bytes_low_r <= '0;
        bytes_high_r <= '0;
      end
    end
  end

  assign out_word.valid = out_valid_r;
  assign out_word.status = status_r;
  assign out_word.bytes_low = bytes_low_r;
  assign out_word.bytes_high = bytes_high_r;

endmodule
